@@ rtl/bskl_pkg.sv @@
// ----------------------------------------------------------------------------
// bskl_pkg
// Shared types and codes for the bounded sorted key list.
// ----------------------------------------------------------------------------
package bskl_pkg;

    localparam int KEY_W   = 18;  // key field width
    localparam int POS_W   = 4;   // position field width
    localparam int COUNT_W = 5;   // entry count field width

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHUP,
        S_PUT,
        S_SHDN,
        S_DRAIN,
        S_REPORT
    } t_state;

    typedef struct packed {
        t_op              operation;
        logic [KEY_W-1:0] key;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic               has_entry;
        logic [POS_W-1:0]   position;
        logic [KEY_W-1:0]   entry_key;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } t_result;

endpackage

@@ rtl/bskl_store.sv @@
// ----------------------------------------------------------------------------
// bskl_store
// Key storage: one write port, one read port with registered, write-first data.
// ----------------------------------------------------------------------------
module bskl_store #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [bskl_pkg::KEY_W-1:0]   i_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [bskl_pkg::KEY_W-1:0]   o_rdata
);

    logic [bskl_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [bskl_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Forward the word being written when both ports hit the same entry.
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bskl_seq.sv @@
// ----------------------------------------------------------------------------
// bskl_seq
// Sequencer: search with one shared comparator, shift, insert, read out.
// ----------------------------------------------------------------------------
module bskl_seq #(
    parameter int CAPACITY = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  bskl_pkg::t_request           i_request,
    output logic                         o_busy,
    output logic                         o_strobe,
    output bskl_pkg::t_result            o_result,
    output logic                         o_mem_we,
    output logic [$clog2(CAPACITY)-1:0]  o_mem_waddr,
    output logic [bskl_pkg::KEY_W-1:0]   o_mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]  o_mem_raddr,
    input  logic [bskl_pkg::KEY_W-1:0]   i_mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    bskl_pkg::t_state   r_state, n_state;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_count, n_count;
    bskl_pkg::t_op      r_op, n_op;
    logic [bskl_pkg::KEY_W-1:0] r_key, n_key;
    bskl_pkg::t_status  r_status, n_status;
    logic               r_stb, n_stb;
    bskl_pkg::t_result  r_res, n_res;

    logic               accept;
    logic               at_end;
    logic               key_lt;
    logic               key_eq;
    logic               last_ent;
    logic [CW-1:0]      ptr_up;
    logic [CW-1:0]      ptr_dn;
    logic [CW-1:0]      count_dn;

    assign accept   = i_start && (r_state == bskl_pkg::S_IDLE);
    assign ptr_up   = r_ptr + CW'(1);
    assign ptr_dn   = r_ptr - CW'(1);
    assign count_dn = r_count - CW'(1);
    assign at_end   = (r_ptr == r_count);
    assign last_ent = (ptr_up == r_count);

    // Shared compare unit: stored word against the request key.
    assign key_lt = (i_mem_rdata < r_key);
    assign key_eq = (i_mem_rdata == r_key);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bskl_pkg::S_IDLE: begin
                if (accept) begin
                    if ((i_request.operation == bskl_pkg::OP_INSERT)
                            && (r_count == CW'(CAPACITY))) begin
                        n_state = bskl_pkg::S_REPORT;
                    end else begin
                        n_state = bskl_pkg::S_SEARCH;
                    end
                end
            end
            bskl_pkg::S_SEARCH: begin
                if (r_op == bskl_pkg::OP_INSERT) begin
                    if (at_end) begin
                        n_state = bskl_pkg::S_PUT;
                    end else if (!key_lt) begin
                        n_state = bskl_pkg::S_SHUP;
                    end
                end else begin
                    if (at_end) begin
                        n_state = bskl_pkg::S_REPORT;
                    end else if (key_eq) begin
                        if (!last_ent) begin
                            n_state = bskl_pkg::S_SHDN;
                        end else if (r_count == CW'(1)) begin
                            n_state = bskl_pkg::S_REPORT;
                        end else begin
                            n_state = bskl_pkg::S_DRAIN;
                        end
                    end
                end
            end
            bskl_pkg::S_SHUP: begin
                if (r_ptr == r_pos) begin
                    n_state = bskl_pkg::S_PUT;
                end
            end
            bskl_pkg::S_PUT: begin
                n_state = bskl_pkg::S_DRAIN;
            end
            bskl_pkg::S_SHDN: begin
                if (r_ptr == count_dn) begin
                    n_state = bskl_pkg::S_DRAIN;
                end
            end
            bskl_pkg::S_DRAIN: begin
                if (last_ent) begin
                    n_state = bskl_pkg::S_IDLE;
                end
            end
            bskl_pkg::S_REPORT: begin
                n_state = bskl_pkg::S_IDLE;
            end
            default: begin
                n_state = bskl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_count     = r_count;
        n_op        = r_op;
        n_key       = r_key;
        n_status    = r_status;
        n_stb       = 1'b0;
        n_res       = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ptr[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        unique case (r_state)
            bskl_pkg::S_IDLE: begin
                if (accept) begin
                    n_op  = i_request.operation;
                    n_key = i_request.key;
                    n_ptr = '0;
                    if (i_request.operation == bskl_pkg::OP_REMOVE) begin
                        n_status = bskl_pkg::ST_REMOVED;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_status = bskl_pkg::ST_FULL;
                    end else begin
                        n_status = bskl_pkg::ST_INSERTED;
                    end
                end
            end
            bskl_pkg::S_SEARCH: begin
                if (r_op == bskl_pkg::OP_INSERT) begin
                    if (at_end || !key_lt) begin
                        n_pos = r_ptr;
                        n_ptr = count_dn;
                    end else begin
                        n_ptr = ptr_up;
                    end
                end else begin
                    if (at_end) begin
                        n_status = bskl_pkg::ST_MISSING;
                    end else if (key_eq && last_ent) begin
                        n_count = count_dn;
                        n_ptr   = '0;
                    end else begin
                        n_ptr = ptr_up;
                    end
                end
            end
            bskl_pkg::S_SHUP: begin
                // Move one entry up, walking down toward the insert point.
                o_mem_we    = 1'b1;
                o_mem_waddr = ptr_up[AW-1:0];
                if (r_ptr != r_pos) begin
                    n_ptr = ptr_dn;
                end
            end
            bskl_pkg::S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos[AW-1:0];
                o_mem_wdata = r_key;
                n_count     = r_count + CW'(1);
                n_ptr       = '0;
            end
            bskl_pkg::S_SHDN: begin
                // Move one entry down over the removed slot.
                o_mem_we    = 1'b1;
                o_mem_waddr = ptr_dn[AW-1:0];
                if (r_ptr == count_dn) begin
                    n_count = count_dn;
                    n_ptr   = '0;
                end else begin
                    n_ptr = ptr_up;
                end
            end
            bskl_pkg::S_DRAIN: begin
                n_stb             = 1'b1;
                n_res.status      = r_status;
                n_res.has_entry   = 1'b1;
                n_res.position    = bskl_pkg::POS_W'(r_ptr);
                n_res.entry_key   = i_mem_rdata;
                n_res.entry_count = bskl_pkg::COUNT_W'(r_count);
                n_res.last        = last_ent;
                if (!last_ent) begin
                    n_ptr = ptr_up;
                end
            end
            bskl_pkg::S_REPORT: begin
                n_stb             = 1'b1;
                n_res.status      = r_status;
                n_res.entry_count = bskl_pkg::COUNT_W'(r_count);
                n_res.last        = 1'b1;
            end
            default: begin
                n_stb = 1'b0;
            end
        endcase
    end

    // Read the entry the next cycle works on.
    assign o_mem_raddr = n_ptr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bskl_pkg::S_IDLE;
            r_count <= '0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_stb   <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_pos    <= n_pos;
        r_op     <= n_op;
        r_key    <= n_key;
        r_status <= n_status;
        r_res    <= n_res;
    end

    assign o_busy   = (r_state != bskl_pkg::S_IDLE);
    assign o_strobe = r_stb;
    assign o_result = r_res;

endmodule

@@ rtl/bounded_sorted_key_list.sv @@
// ----------------------------------------------------------------------------
// bounded_sorted_key_list
// Ascending list of up to CAPACITY keys with insert and remove requests;
// each request is answered by a readout of the list or a single status.
// ----------------------------------------------------------------------------
//
//  channel   | ports                       | handshake
//  ----------+-----------------------------+------------------------------------
//  request   | start, busy, i_request      | taken when start is high, busy low
//  result    | o_strobe, o_result          | one cycle per result, no back-pressure
//
// Each request walks the list one entry per cycle through the single key
// comparator and the one-read, one-write key store. An insert searches for its
// place, shifts later keys up, writes the key and reads out the list; a remove
// that hits shifts later keys down and reads out the list (a status alone when
// it empties the list); a missing key or a full list gives a status alone. Each
// result is registered and leaves in the cycle after the step that makes it.
// Reset (synchronous, active low) empties the list; stored words are not
// cleared, as only entries below the count are ever used.
// The receiver cannot stall: each result stands for exactly one cycle.
//
module bounded_sorted_key_list #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  bskl_pkg::t_request i_request,
    output logic               busy,
    output logic               o_strobe,
    output bskl_pkg::t_result  o_result
);

    localparam int AW = $clog2(CAPACITY);

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [bskl_pkg::KEY_W-1:0] mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [bskl_pkg::KEY_W-1:0] mem_rdata;

    // Key storage; read data is registered and lands in the cycle after the address.
    bskl_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Search, shift and readout sequencer around the shared comparator.
    bskl_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_request   (i_request),
        .o_busy      (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule
